FILE: rtl/core/sps_pkg.sv
`default_nettype none
package sps_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int ROW_BITS    = 64;

	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_QUERY  = 3'd1,
		CMD_ADV    = 3'd2,
		CMD_APPEND = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_e;

	localparam logic [2:0] DIR_RIGHT    = 3'd0;
	localparam logic [2:0] DIR_LEFT     = 3'd1;
	localparam logic [2:0] DIR_STRAIGHT = 3'd2;
	localparam logic [2:0] DIR_UTURN    = 3'd3;
	localparam logic [2:0] DIR_ANY      = 3'd4;
	localparam logic [2:0] DIR_RSTR     = 3'd5;
	localparam logic [2:0] DIR_LSTR     = 3'd6;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK,
		S_QRY,
		S_MOD,
		S_WALK_RD,
		S_WALK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]             cmd;
		logic [2:0]             street;
		logic [2:0]             direction;
		logic [OFFSET_BITS-1:0] offset;
		logic [15:0]            duration;
		logic [ROW_BITS-1:0]    green_row;
	} in_t;

	typedef struct packed {
		logic       green;
		logic [1:0] status;
		logic [3:0] phase_now;
		logic [15:0] ticks_now;
	} out_t;

	// exact bit, then any, then compound fallbacks
	function automatic logic resolve(input logic [6:0] mask, input logic [2:0] dir);
		logic r;
		r = 1'b0;
		if (dir != 3'd7 && mask[dir]) r = 1'b1;
		else if (mask[DIR_ANY]) r = 1'b1;
		else begin
			case (dir)
				DIR_RIGHT:    r = mask[DIR_RSTR];
				DIR_LEFT:     r = mask[DIR_LSTR];
				DIR_STRAIGHT: r = mask[DIR_RSTR] | mask[DIR_LSTR];
				DIR_UTURN:    r = mask[DIR_LEFT] | mask[DIR_LSTR];
				default:      r = 1'b0;
			endcase
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sps_ram.sv
`default_nettype none
module sps_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/core/signal_phase_sequencer_top.sv
`default_nettype none
// Fixed-time signal phase sequencer. Phases (duration plus a green row) sit in
// one synchronous RAM; one command is handled at a time. Append, clear, and commands
// on an empty table go straight to the done state; tick and query first do one RAM
// read. Advance reduces the offset modulo the cycle total (one offset bit a cycle),
// then walks the phase boundaries crossed, each with a RAM read, at most MAX_PHASES
// of them, and then finishes. A stalled result holds the block in its done state.
// A new command is taken once the previous result is in the output register.
module signal_phase_sequencer_top
	import sps_pkg::*;
#(
	parameter int MAX_PHASES    = 16,
	parameter int NUM_STREETS   = 8,
	parameter int DURATION_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_wen,
	input  wire logic cfg_wdata,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_stall,
	output out_t      out_data
);
	localparam int PW = $clog2(MAX_PHASES);
	localparam int CW = $clog2(MAX_PHASES + 1);
	localparam int DB = DURATION_BITS;
	localparam int SW = DB + CW;
	localparam int MW = DB + ROW_BITS;

	state_t state_q, state_d;
	logic aft_q;
	logic [CW-1:0] total_q, total_d;
	logic [PW-1:0] act_q, act_d;
	logic [DB-1:0] tick_q, tick_d;
	logic [SW-1:0] sum_q, sum_d;
	logic [SW-1:0] acc_q, acc_d;
	logic [OFFSET_BITS-1:0] div_q, div_d;
	logic [4:0] cnt_q, cnt_d;
	logic [2:0] street_q, street_d, dir_q, dir_d;
	logic green_q, green_d;
	logic [1:0] status_q, status_d;
	logic out_valid_q, out_valid_d;
	out_t out_q, out_d;

	logic we;
	logic [MW-1:0] wdata, rdata;
	logic [DB-1:0] rd_len;
	logic [ROW_BITS-1:0] rd_row;
	logic [DB-1:0] dur;
	logic [DB+15:0] dur_ext;
	logic [PW:0] nxt_sum;
	logic [PW-1:0] nxt_phase;
	logic [DB:0] tick_inc;
	logic [DB-1:0] rem;
	logic [SW:0] acc_sh, acc_sub;
	logic [7:0] field;
	logic [PW+3:0] ph_ext;
	logic [DB+15:0] tk_ext;

	assign dur_ext = {{DB{1'b0}}, in_data.duration};
	assign dur     = dur_ext[DB-1:0];
	assign wdata   = {dur, in_data.green_row};
	assign rd_len  = rdata[MW-1:ROW_BITS];
	assign rd_row  = rdata[ROW_BITS-1:0];

	sps_ram #(.WIDTH(MW), .DEPTH(MAX_PHASES)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(total_q[PW-1:0]),
		.wdata(wdata),
		.raddr(act_q),
		.rdata(rdata)
	);

	assign nxt_sum   = {1'b0, act_q} + 1'b1;
	assign nxt_phase = ((CW+1)'(nxt_sum) >= (CW+1)'(total_q)) ? '0 : nxt_sum[PW-1:0];
	assign tick_inc  = {1'b0, tick_q} + 1'b1;
	assign rem       = rd_len - tick_q;
	assign acc_sh    = {acc_q, div_q[OFFSET_BITS-1]};
	assign acc_sub   = acc_sh - {1'b0, sum_q};
	assign field     = rd_row[{street_q, 3'b000} +: 8];
	assign ph_ext    = {4'b0, act_q};
	assign tk_ext    = {16'b0, tick_q};

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		state_d     = state_q;
		total_d     = total_q;
		act_d       = act_q;
		tick_d      = tick_q;
		sum_d       = sum_q;
		acc_d       = acc_q;
		div_d       = div_q;
		cnt_d       = cnt_q;
		street_d    = street_q;
		dir_d       = dir_q;
		green_d     = green_q;
		status_d    = status_q;
		out_valid_d = out_valid_q & out_stall;
		out_d       = out_q;
		we          = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					green_d  = 1'b0;
					status_d = ST_OK;
					street_d = in_data.street;
					dir_d    = in_data.direction;
					state_d  = S_DONE;
					case (in_data.cmd)
						CMD_TICK: if (total_q != '0) state_d = S_TICK;
						CMD_QUERY: begin
							if (total_q == '0 || {1'b0, in_data.street} >= 4'(NUM_STREETS))
								green_d = aft_q;
							else
								state_d = S_QRY;
						end
						CMD_ADV: begin
							if (total_q != '0 && in_data.offset != '0) begin
								div_d   = in_data.offset;
								acc_d   = '0;
								cnt_d   = '0;
								state_d = S_MOD;
							end
						end
						CMD_APPEND: begin
							if (dur == '0) status_d = ST_ZERO;
							else if (total_q == CW'(MAX_PHASES)) status_d = ST_FULL;
							else begin
								we      = 1'b1;
								total_d = total_q + 1'b1;
								sum_d   = sum_q + SW'(dur);
								act_d   = '0;
								tick_d  = '0;
							end
						end
						CMD_CLEAR: begin
							total_d = '0;
							sum_d   = '0;
							act_d   = '0;
							tick_d  = '0;
						end
						default: ;
					endcase
				end
			end
			S_TICK: begin
				if (tick_inc >= {1'b0, rd_len}) begin
					tick_d = '0;
					act_d  = nxt_phase;
				end else
					tick_d = tick_inc[DB-1:0];
				state_d = S_DONE;
			end
			S_QRY: begin
				green_d = field[7] ? resolve(field[6:0], dir_q) : aft_q;
				state_d = S_DONE;
			end
			S_MOD: begin
				// restoring remainder, one offset bit a cycle
				acc_d = acc_sh >= {1'b0, sum_q} ? acc_sub[SW-1:0] : acc_sh[SW-1:0];
				div_d = {div_q[OFFSET_BITS-2:0], 1'b0};
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == 5'd31) state_d = S_WALK;
			end
			S_WALK_RD: state_d = S_WALK;
			S_WALK: begin
				if (acc_q == '0) state_d = S_DONE;
				else if (acc_q < SW'(rem)) begin
					tick_d  = tick_q + acc_q[DB-1:0];
					state_d = S_DONE;
				end else begin
					acc_d   = acc_q - SW'(rem);
					tick_d  = '0;
					act_d   = nxt_phase;
					state_d = S_WALK_RD;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_valid_d     = 1'b1;
					out_d.green     = green_q;
					out_d.status    = status_q;
					out_d.phase_now = ph_ext[3:0];
					out_d.ticks_now = tk_ext[15:0];
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			aft_q       <= 1'b0;
			total_q     <= '0;
			act_q       <= '0;
			tick_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			if (cfg_wen) aft_q <= cfg_wdata;
			total_q     <= total_d;
			act_q       <= act_d;
			tick_q      <= tick_d;
			sum_q       <= sum_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		acc_q    <= acc_d;
		div_q    <= div_d;
		cnt_q    <= cnt_d;
		street_q <= street_d;
		dir_q    <= dir_d;
		green_q  <= green_d;
		status_q <= status_d;
		out_q    <= out_d;
	end
endmodule
`default_nettype wire

FILE: test/signal_phase_sequencer_top_tb.sv
`timescale 1ns / 1ps
module signal_phase_sequencer_top_tb;
	import sps_pkg::*;

	localparam int PHASE_SLOTS  = 16;
	localparam int STREET_COUNT = 8;
	localparam int RANDOM_ITEMS = 1650;
	localparam int SETTLE_CYCLES = 80;
	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam logic [2:0] DIR_NONE     = 3'd7;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic cfg_wdata;
	logic in_valid;
	logic in_stall;
	in_t  in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;

	signal_phase_sequencer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// shadow of the sequencer
	logic [15:0] sh_len [PHASE_SLOTS];
	logic [63:0] sh_row [PHASE_SLOTS];
	int unsigned sh_total;
	int unsigned sh_phase;
	int unsigned sh_ticks;
	longint unsigned sh_cycle;
	bit sh_free;

	out_t pending_results[$];
	int   fail_count;
	bit   calm;
	int   sent_count;

	// directed stimulus
	in_t  dir_items [$];
	bit   dir_known [$];
	out_t dir_res   [$];

	function automatic bit dir_allowed(logic [6:0] mask, logic [2:0] d);
		if (d != DIR_NONE && mask[d])
			return 1'b1;
		if (mask[DIR_ANY])
			return 1'b1;
		case (d)
			DIR_RIGHT:    return mask[DIR_RSTR];
			DIR_LEFT:     return mask[DIR_LSTR];
			DIR_STRAIGHT: return mask[DIR_RSTR] | mask[DIR_LSTR];
			DIR_UTURN:    return mask[DIR_LEFT] | mask[DIR_LSTR];
			default:      return 1'b0;
		endcase
	endfunction

	function automatic out_t step_sequencer(in_t it);
		out_t r;
		logic [7:0] field;
		longint unsigned skip;
		longint unsigned left;
		r = '0;
		case (it.cmd)
			CMD_TICK: begin
				if (sh_total != 0) begin
					sh_ticks++;
					if (sh_ticks >= sh_len[sh_phase]) begin
						sh_ticks = 0;
						sh_phase = (sh_phase + 1 >= sh_total) ? 0 : sh_phase + 1;
					end
				end
			end
			CMD_QUERY: begin
				if (sh_total == 0 || it.street >= STREET_COUNT) begin
					r.green = sh_free;
				end else begin
					field = sh_row[sh_phase][8*it.street +: 8];
					r.green = field[7] ? dir_allowed(field[6:0], it.direction) : sh_free;
				end
			end
			CMD_ADV: begin
				if (sh_total != 0 && it.offset != 0 && sh_cycle != 0) begin
					skip = longint'(it.offset) % sh_cycle;
					while (skip > 0) begin
						left = sh_len[sh_phase] - sh_ticks;
						if (skip < left) begin
							sh_ticks += skip;
							break;
						end
						skip -= left;
						sh_ticks = 0;
						sh_phase = (sh_phase + 1 >= sh_total) ? 0 : sh_phase + 1;
					end
				end
			end
			CMD_APPEND: begin
				if (it.duration == 0) begin
					r.status = ST_ZERO;
				end else if (sh_total >= PHASE_SLOTS) begin
					r.status = ST_FULL;
				end else begin
					sh_len[sh_total] = it.duration;
					sh_row[sh_total] = it.green_row;
					sh_total++;
					sh_cycle += it.duration;
					sh_phase = 0;
					sh_ticks = 0;
				end
			end
			CMD_CLEAR: begin
				sh_total = 0;
				sh_cycle = 0;
				sh_phase = 0;
				sh_ticks = 0;
			end
			default: ;
		endcase
		r.phase_now = sh_phase[3:0];
		r.ticks_now = sh_ticks[15:0];
		return r;
	endfunction

	function automatic in_t make_item(logic [2:0] c, logic [2:0] s, logic [2:0] d,
		logic [31:0] off, logic [15:0] dur, logic [63:0] row);
		in_t it;
		it.cmd = c;
		it.street = s;
		it.direction = d;
		it.offset = off;
		it.duration = dur;
		it.green_row = row;
		return it;
	endfunction

	function automatic in_t noise_fill(in_t it);
		in_t n;
		n = it;
		if (n.cmd != CMD_QUERY) begin
			n.street = 3'($urandom);
			n.direction = 3'($urandom);
		end
		if (n.cmd != CMD_ADV)
			n.offset = $urandom;
		if (n.cmd != CMD_APPEND) begin
			n.duration = 16'($urandom);
			n.green_row = {$urandom, $urandom};
		end
		return n;
	endfunction

	task automatic add_row(in_t it, bit known, out_t res);
		dir_items.insert(dir_items.size(), it);
		dir_known.insert(dir_known.size(), known);
		dir_res.insert(dir_res.size(), res);
	endtask

	task automatic send_item(in_t it, bit known, out_t res);
		out_t exp_r;
		if (!calm && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do
			@(posedge clk);
		while (in_stall);
		exp_r = step_sequencer(it);
		pending_results.insert(pending_results.size(), known ? res : exp_r);
		sent_count++;
	endtask

	task automatic set_free_turns(bit v);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sh_free = v;
	endtask

	always @(posedge clk) begin
		out_stall <= (!calm && $urandom_range(0, 99) < 20);
	end

	always @(posedge clk) begin
		out_t want;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected: %h", $time, out_data);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.green !== want.green) begin
					$display("%0t: green expected %0d actual %0d", $time, want.green,
						out_data.green);
					fail_count++;
				end
				if (out_data.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						out_data.status);
					fail_count++;
				end
				if (out_data.phase_now !== want.phase_now) begin
					$display("%0t: phase expected %0d actual %0d", $time, want.phase_now,
						out_data.phase_now);
					fail_count++;
				end
				if (out_data.ticks_now !== want.ticks_now) begin
					$display("%0t: ticks expected %0d actual %0d", $time, want.ticks_now,
						out_data.ticks_now);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		out_t zero_r;
		out_t rz;
		in_t it;
		int n_app;
		int n_ops;
		int pick;
		int episode;
		zero_r = '0;
		rz = '0;
		rz.status = ST_ZERO;
		fail_count = 0;
		calm = 1'b0;
		sent_count = 0;
		sh_total = 0;
		sh_phase = 0;
		sh_ticks = 0;
		sh_cycle = 0;
		sh_free = 1'b0;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, then rejects, then a small table walked by hand
		add_row(make_item(CMD_QUERY, 3'd7, DIR_NONE, '0, '0, '1), 1, zero_r);
		add_row(make_item(CMD_TICK, '0, '0, '1, '1, '1), 1, zero_r);
		add_row(make_item(CMD_ADV, '0, '0, 32'hFFFF_FFFF, '0, '0), 1, zero_r);
		add_row(make_item(CMD_APPEND, '0, '0, '0, 16'd0, '1), 1, rz);
		add_row(make_item(CMD_APPEND, '0, '0, '0, 16'd3, 64'hFFFF_FFFF_FFFF_FFFF), 1, zero_r);
		add_row(make_item(CMD_APPEND, '0, '0, '0, 16'hFFFF, 64'h0), 1, zero_r);
		add_row(make_item(CMD_APPEND, '0, '0, '0, 16'd1,
			64'h00_C2_A0_81_C0_E0_84_A1), 1, zero_r);
		add_row(make_item(CMD_QUERY, 3'd0, DIR_NONE, '0, '0, '0), 0, zero_r);
		add_row(make_item(CMD_TICK, '0, '0, '0, '0, '0), 0, zero_r);
		add_row(make_item(CMD_TICK, '0, '0, '0, '0, '0), 0, zero_r);
		add_row(make_item(CMD_TICK, '0, '0, '0, '0, '0), 0, zero_r);
		add_row(make_item(CMD_QUERY, 3'd7, DIR_UTURN, '0, '0, '0), 0, zero_r);
		add_row(make_item(CMD_ADV, '0, '0, 32'd0, '0, '0), 0, zero_r);
		add_row(make_item(CMD_ADV, '0, '0, 32'd65538, '0, '0), 0, zero_r);
		add_row(make_item(CMD_QUERY, 3'd0, DIR_RIGHT, '0, '0, '0), 0, zero_r);
		add_row(make_item(CMD_ADV, '0, '0, 32'hFFFF_FFFF, '0, '0), 0, zero_r);
		add_row(make_item(CMD_QUERY, 3'd1, DIR_STRAIGHT, '0, '0, '0), 0, zero_r);
		add_row(make_item(CMD_SPARE_LO, '1, '1, '1, '1, '1), 0, zero_r);
		add_row(make_item(CMD_SPARE_HI, '0, '0, '0, '0, '0), 0, zero_r);
		add_row(make_item(CMD_CLEAR, '1, '1, '1, '1, '1), 1, zero_r);
		add_row(make_item(CMD_QUERY, 3'd2, DIR_LSTR, '0, '0, '0), 1, zero_r);
		foreach (dir_items[i])
			send_item(dir_items[i], dir_known[i], dir_res[i]);

		set_free_turns(1'b1);
		episode = 0;
		sent_count = 0;
		while (sent_count < RANDOM_ITEMS) begin
			if (episode % 6 == 5)
				set_free_turns($urandom_range(0, 1));
			episode++;
			calm = (sent_count > 700 && sent_count < 950);
			if ($urandom_range(0, 9) == 0) begin
				// noise: any code, any content
				repeat ($urandom_range(5, 20)) begin
					it = make_item(3'($urandom), '0, '0, '0, '0, '0);
					send_item(noise_fill(it), 0, zero_r);
				end
				continue;
			end
			if ($urandom_range(0, 2) != 0)
				send_item(noise_fill(make_item(CMD_CLEAR, '0, '0, '0, '0, '0)), 0, zero_r);
			n_app = $urandom_range(1, 17);
			repeat (n_app) begin
				it = make_item(CMD_APPEND, '0, '0, '0, 16'($urandom_range(1, 12)),
					{$urandom, $urandom});
				pick = $urandom_range(0, 99);
				if (pick < 5)
					it.duration = '0;
				else if (pick < 15)
					it.duration = 16'($urandom);
				send_item(noise_fill(it), 0, zero_r);
			end
			n_ops = $urandom_range(10, 40);
			repeat (n_ops) begin
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					it = make_item(CMD_TICK, '0, '0, '0, '0, '0);
				end else if (pick < 75) begin
					it = make_item(CMD_QUERY, 3'($urandom), 3'($urandom), '0, '0, '0);
				end else if (pick < 90) begin
					it = make_item(CMD_ADV, '0, '0,
						($urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 40))),
						'0, '0);
				end else if (pick < 95) begin
					it = make_item(CMD_APPEND, '0, '0, '0, 16'($urandom), {$urandom, $urandom});
				end else begin
					it = make_item(3'($urandom_range(CMD_CLEAR, CMD_SPARE_HI)),
						'0, '0, '0, '0, '0);
				end
				send_item(noise_fill(it), 0, zero_r);
			end
		end
		calm = 1'b0;
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
